### sv/ecd_pkg.sv
// Shared types, constants and tables for the epoch-to-calendar converter.
// No dependencies; used by every module of the block.
package ecd_pkg;

    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic [19:0] sub_second_in;
    } t_in_beat;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [19:0] sub_second_out;
        logic        out_of_range;
    } t_out_beat;

    // Stage 2 result of the front end.
    typedef struct packed {
        logic [16:0] rem;    // seconds into the day
        logic [7:0]  yq;     // estimated years since the base year
        logic [17:0] yd0;    // day of year for the estimate (two's complement)
        logic [17:0] yd1;    // day of year for the estimate minus one
    } t_front;

    localparam int NSTAGE = 5;

    localparam logic [31:0] LAST_SECOND = 32'd4102444799;
    localparam logic [19:0] USEC_MAX    = 20'd999999;
    localparam logic [11:0] BASE_YEAR   = 12'd1970;
    localparam logic [17:0] DAYS_PER_YEAR = 18'd365;

    // Both 86400 and 31536000 carry a factor of 128; the rest is a reciprocal
    // multiply on the upper 25 bits of the seconds.
    localparam int PRE_SHIFT = 7;

    localparam longint unsigned DAY_DIV = 64'd675;
    localparam int              DAY_K   = 35;
    localparam longint unsigned DAY_MUL = ((64'd1 << DAY_K) + DAY_DIV - 64'd1) / DAY_DIV;

    localparam longint unsigned YR_DIV = 64'd246375;
    localparam int              YR_K   = 43;
    localparam longint unsigned YR_MUL = ((64'd1 << YR_K) + YR_DIV - 64'd1) / YR_DIV;

    // hour = (rem >> 4) / 225, minute = (r >> 2) / 15
    localparam longint unsigned HR_DIV = 64'd225;
    localparam int              HR_K   = 21;
    localparam longint unsigned HR_MUL = ((64'd1 << HR_K) + HR_DIV - 64'd1) / HR_DIV;

    localparam longint unsigned MIN_DIV = 64'd15;
    localparam int              MIN_K   = 14;
    localparam longint unsigned MIN_MUL = ((64'd1 << MIN_K) + MIN_DIV - 64'd1) / MIN_DIV;

    localparam logic [8:0] CUM_DAYS [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

endpackage

### sv/ecd_front.sv
// Stages 1-2: whole days, seconds of day and year estimate by reciprocal multiply.
// Depends on ecd_pkg.
module ecd_front (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [31:0]       i_secs,
    output ecd_pkg::t_front   o_front
);

    logic [50:0] r_dprod, n_dprod;
    logic [50:0] r_yprod, n_yprod;
    logic [31:0] r_secs;

    always_comb begin
        n_dprod = 51'(i_secs[31:ecd_pkg::PRE_SHIFT]) * 51'(ecd_pkg::DAY_MUL);
        n_yprod = 51'(i_secs[31:ecd_pkg::PRE_SHIFT]) * 51'(ecd_pkg::YR_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dprod <= n_dprod;
            r_yprod <= n_yprod;
            r_secs  <= i_secs;
        end
    end

    logic [15:0] days;
    logic [7:0]  yq;
    logic [25:0] days_x;
    logic [24:0] rlo;
    logic [17:0] yspan, leaps0, leaps1;
    ecd_pkg::t_front r_front, n_front;

    always_comb begin
        days   = r_dprod[50:ecd_pkg::DAY_K];
        yq     = r_yprod[50:ecd_pkg::YR_K];
        days_x = 26'(days) * 26'(ecd_pkg::DAY_DIV);
        rlo    = r_secs[31:ecd_pkg::PRE_SHIFT] - days_x[24:0];
        yspan  = 18'(yq) * ecd_pkg::DAYS_PER_YEAR;
        leaps0 = 18'((9'(yq) + 9'd1) >> 2);
        leaps1 = 18'(yq >> 2);
        n_front.rem = {rlo[9:0], r_secs[ecd_pkg::PRE_SHIFT-1:0]};
        n_front.yq  = yq;
        n_front.yd0 = 18'(days) - yspan - leaps0 + 18'd1;
        // one year earlier: 365 more days, and one leap fewer when yq+1 is a multiple of 4
        n_front.yd1 = n_front.yd0 + ecd_pkg::DAYS_PER_YEAR + leaps0 - leaps1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

### sv/ecd_date.sv
// Stages 3-5: year correction, month search and day of month.
// Depends on ecd_pkg.
module ecd_date (
    input  logic              i_clk,
    input  logic              i_en,
    input  ecd_pkg::t_front   i_front,
    output logic [11:0]       o_year,
    output logic [3:0]        o_month,
    output logic [4:0]        o_day
);

    // stage 3
    logic        sel;
    logic [17:0] yd;
    logic [7:0]  n3_yoff, r3_yoff;
    logic [8:0]  n3_ydu, r3_ydu;
    logic        n3_leap, r3_leap;

    always_comb begin
        sel     = i_front.yd0[17] || (i_front.yd0 == '0);
        n3_yoff = sel ? (i_front.yq - 8'd1) : i_front.yq;
        yd      = sel ? i_front.yd1 : i_front.yd0;
        n3_ydu  = (yd[17] || (yd == '0)) ? 9'd1 : yd[8:0];
        // 1970 is 2 mod 4; 2100 is out of reach, so every fourth year leaps
        n3_leap = (n3_yoff[1:0] == 2'b10);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_yoff <= n3_yoff;
            r3_ydu  <= n3_ydu;
            r3_leap <= n3_leap;
        end
    end

    // stage 4
    logic [3:0] n4_month, r4_month;
    logic [7:0] r4_yoff;
    logic [8:0] r4_ydu;
    logic       r4_leap;
    logic [8:0] start;

    always_comb begin
        n4_month = 4'd1;
        start    = '0;
        for (int i = 1; i < 12; i++) begin
            start = ecd_pkg::CUM_DAYS[i] + ((i >= 2) ? 9'(r3_leap) : 9'd0);
            if (r3_ydu > start) begin
                n4_month = 4'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_month <= n4_month;
            r4_yoff  <= r3_yoff;
            r4_ydu   <= r3_ydu;
            r4_leap  <= r3_leap;
        end
    end

    // stage 5
    logic [11:0] n5_year, r5_year;
    logic [3:0]  r5_month;
    logic [8:0]  dfull;
    logic [4:0]  r5_day;

    always_comb begin
        n5_year = ecd_pkg::BASE_YEAR + 12'(r4_yoff);
        dfull   = r4_ydu - ecd_pkg::CUM_DAYS[r4_month - 4'd1]
                  - ((r4_month >= 4'd3) ? 9'(r4_leap) : 9'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_year  <= n5_year;
            r5_month <= r4_month;
            r5_day   <= dfull[4:0];
        end
    end

    assign o_year  = r5_year;
    assign o_month = r5_month;
    assign o_day   = r5_day;

endmodule

### sv/ecd_tod.sv
// Stages 3-5: hour, minute and second from the seconds into the day.
// Depends on ecd_pkg.
module ecd_tod (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [16:0] i_rem,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    // stage 3: hour = (rem / 16) / 225
    logic [26:0] hprod;
    logic [16:0] r3_rem;
    logic [4:0]  r3_hour;

    assign hprod = 27'(i_rem[16:4]) * 27'(ecd_pkg::HR_MUL);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_rem  <= i_rem;
            r3_hour <= hprod[ecd_pkg::HR_K+4:ecd_pkg::HR_K];
        end
    end

    // stage 4: seconds into the hour
    logic [16:0] r2full;
    logic [11:0] r4_r2;
    logic [4:0]  r4_hour;

    assign r2full = r3_rem - 17'(r3_hour) * 17'd3600;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_r2   <= r2full[11:0];
            r4_hour <= r3_hour;
        end
    end

    // stage 5: minute = (r2 / 4) / 15
    logic [20:0] mprod;
    logic [5:0]  minute;
    logic [11:0] sfull;
    logic [4:0]  r5_hour;
    logic [5:0]  r5_minute, r5_second;

    always_comb begin
        mprod  = 21'(r4_r2[11:2]) * 21'(ecd_pkg::MIN_MUL);
        minute = mprod[ecd_pkg::MIN_K+5:ecd_pkg::MIN_K];
        sfull  = r4_r2 - 12'(minute) * 12'd60;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_hour   <= r4_hour;
            r5_minute <= minute;
            r5_second <= sfull[5:0];
        end
    end

    assign o_hour   = r5_hour;
    assign o_minute = r5_minute;
    assign o_second = r5_second;

endmodule

### sv/epoch_seconds_to_calendar_date.sv
// Channel  | valid      | ready       | payload
// in       | i_in_valid | o_in_ready  | i_in_beat  (ecd_pkg::t_in_beat)
// out      | o_out_valid| i_out_ready | o_out_beat (ecd_pkg::t_out_beat)
//
// Five register stages; a taken beat moves through them in order and is shown
// from the last, one beat per cycle sustained unless the output stalls. The two
// 25x26-bit reciprocal multiplies in stage 1 set the stage depth. The whole pipe
// holds when the output beat waits and i_out_ready is low; o_in_ready is low only
// then. Synchronous reset clears the valid bits only.
// Depends on ecd_pkg, ecd_front, ecd_date, ecd_tod.
module epoch_seconds_to_calendar_date (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ecd_pkg::t_in_beat    i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ecd_pkg::t_out_beat   o_out_beat
);

    localparam int LAST = ecd_pkg::NSTAGE - 1;

    logic [ecd_pkg::NSTAGE-1:0] r_vld;
    logic                       r_oor  [ecd_pkg::NSTAGE];
    logic [19:0]                r_usec [ecd_pkg::NSTAGE];
    logic                       n_oor;
    logic [19:0]                n_usec;

    logic en;
    assign en         = !r_vld[LAST] || i_out_ready;
    assign o_in_ready = en;

    always_comb begin
        n_oor  = i_in_beat.epoch_seconds > ecd_pkg::LAST_SECOND;
        n_usec = (i_in_beat.sub_second_in > ecd_pkg::USEC_MAX) ? ecd_pkg::USEC_MAX
                                                              : i_in_beat.sub_second_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oor[0]  <= n_oor;
            r_usec[0] <= n_usec;
            for (int s = 1; s < ecd_pkg::NSTAGE; s++) begin
                r_oor[s]  <= r_oor[s-1];
                r_usec[s] <= r_usec[s-1];
            end
        end
    end

    ecd_pkg::t_front front;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute, second;

    ecd_front u_front (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_secs  (i_in_beat.epoch_seconds),
        .o_front (front)
    );

    ecd_date u_date (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_front (front),
        .o_year  (year),
        .o_month (month),
        .o_day   (day)
    );

    ecd_tod u_tod (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_rem    (front.rem),
        .o_hour   (hour),
        .o_minute (minute),
        .o_second (second)
    );

    // past the end of 2099 the date saturates to the last second
    always_comb begin
        o_out_beat.sub_second_out = r_usec[LAST];
        o_out_beat.out_of_range   = r_oor[LAST];
        if (r_oor[LAST]) begin
            o_out_beat.year   = 12'd2099;
            o_out_beat.month  = 4'd12;
            o_out_beat.day    = 5'd31;
            o_out_beat.hour   = 5'd23;
            o_out_beat.minute = 6'd59;
            o_out_beat.second = 6'd59;
        end else begin
            o_out_beat.year   = year;
            o_out_beat.month  = month;
            o_out_beat.day    = day;
            o_out_beat.hour   = hour;
            o_out_beat.minute = minute;
            o_out_beat.second = second;
        end
    end

    assign o_out_valid = r_vld[LAST];

endmodule

### sv/ecd_checker.sv
// Port-level checks for the epoch-to-calendar converter, bound to the top level.
// Depends on ecd_pkg and epoch_seconds_to_calendar_date.
module ecd_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input ecd_pkg::t_in_beat    i_in_beat,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input ecd_pkg::t_out_beat   o_out_beat
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat dropped or changed while stalled");

    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output");

    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.out_of_range |->
            o_out_beat.year == 12'd2099 && o_out_beat.month == 4'd12 &&
            o_out_beat.day == 5'd31 && o_out_beat.hour == 5'd23 &&
            o_out_beat.minute == 6'd59 && o_out_beat.second == 6'd59)
        else $error("out-of-range beat not saturated");

    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_beat.year >= 12'd1970 && o_out_beat.year <= 12'd2099 &&
            o_out_beat.month >= 4'd1 && o_out_beat.month <= 4'd12 &&
            o_out_beat.day >= 5'd1 && o_out_beat.hour <= 5'd23 &&
            o_out_beat.minute <= 6'd59 && o_out_beat.second <= 6'd59 &&
            o_out_beat.sub_second_out <= 20'd999999)
        else $error("output field out of its range");

endmodule

bind epoch_seconds_to_calendar_date ecd_checker u_ecd_checker (.*);

### bench/tb_epoch_seconds_to_calendar_date.sv
`timescale 1ns / 100ps
// Testbench for epoch_seconds_to_calendar_date: a scoreboard class predicts each date
// and checks output beats in order, under random idling and a long output hold-off.
// Depends on ecd_pkg and the block's RTL.
module tb_epoch_seconds_to_calendar_date;

    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 64;
    localparam int PHASE_BEATS  = 250;

    typedef enum int {
        ANY_SECOND,
        CALENDAR_DATE,
        YEAR_EDGE,
        PAST_END,
        RAW_WORD
    } t_stim_kind;

    class calendar_scoreboard;
        ecd_pkg::t_out_beat pending_dates[$];
        int                 errors = 0;

        function ecd_pkg::t_out_beat predict_date(ecd_pkg::t_in_beat b);
            ecd_pkg::t_out_beat r;
            longint    secs;
            longint    days;
            longint    rem;
            longint    yr;
            longint    yd;
            longint    leap;
            longint    start;
            int        mon;
            secs = b.epoch_seconds;
            r.sub_second_out = (b.sub_second_in > ecd_pkg::USEC_MAX) ? ecd_pkg::USEC_MAX
                                                                     : b.sub_second_in;
            if (secs > ecd_pkg::LAST_SECOND) begin
                r.year = 12'd2099;
                r.month = 4'd12;
                r.day = 5'd31;
                r.hour = 5'd23;
                r.minute = 6'd59;
                r.second = 6'd59;
                r.out_of_range = 1'b1;
            end else begin
                days = secs / 86400;
                rem = secs % 86400;
                r.hour = 5'(rem / 3600);
                r.minute = 6'((rem % 3600) / 60);
                r.second = 6'(rem % 60);
                // first guess assumes 365-day years, so it can run one year ahead
                yr = secs / 31536000 + 1970;
                yd = days - 365 * (yr - 1970) - (yr - 1969) / 4 + 1;
                if (yd <= 0) begin
                    yr = yr - 1;
                    yd = days - 365 * (yr - 1970) - (yr - 1969) / 4 + 1;
                end
                if (yd < 1) begin
                    yd = 1;
                end
                leap = (((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0) ? 1 : 0;
                mon = 1;
                for (int i = 1; i < 12; i++) begin
                    start = ecd_pkg::CUM_DAYS[i] + ((i >= 2) ? leap : 0);
                    if (yd > start) begin
                        mon = i + 1;
                    end
                end
                r.year = 12'(yr);
                r.month = 4'(mon);
                r.day = 5'(yd - ecd_pkg::CUM_DAYS[mon - 1] - ((mon >= 3) ? leap : 0));
                r.out_of_range = 1'b0;
            end
            return r;
        endfunction

        function void note_input(ecd_pkg::t_in_beat b);
            pending_dates.push_back(predict_date(b));
        endfunction

        function void compare_field(string name, longint exp_val, longint act_val);
            if (exp_val != act_val) begin
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(ecd_pkg::t_out_beat got);
            ecd_pkg::t_out_beat want;
            if (pending_dates.size() == 0) begin
                $error("output beat with no date pending: year %0d month %0d day %0d",
                       got.year, got.month, got.day);
                errors++;
            end else begin
                want = pending_dates.pop_front();
                compare_field("year", want.year, got.year);
                compare_field("month", want.month, got.month);
                compare_field("day", want.day, got.day);
                compare_field("hour", want.hour, got.hour);
                compare_field("minute", want.minute, got.minute);
                compare_field("second", want.second, got.second);
                compare_field("sub_second_out", want.sub_second_out, got.sub_second_out);
                compare_field("out_of_range", want.out_of_range, got.out_of_range);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    ecd_pkg::t_in_beat  i_in_beat = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    ecd_pkg::t_out_beat o_out_beat;

    calendar_scoreboard board = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_request = 0;
    int hold_off_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    epoch_seconds_to_calendar_date dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    always #5 i_clk = ~i_clk;

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (hold_off_served != hold_off_request) begin
            hold_off_served <= hold_off_request;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            board.note_input(i_in_beat);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result(o_out_beat);
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("FAIL epoch_seconds_to_calendar_date");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [31:0] secs_at(int y, int m, int d, int hh, int mm, int ss);
        longint days;
        bit     leap;
        leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        days = 365 * (y - 1970) + (y - 1969) / 4 + ecd_pkg::CUM_DAYS[m - 1]
             + ((leap && m > 2) ? 1 : 0) + d - 1;
        return 32'(days * 86400 + hh * 3600 + mm * 60 + ss);
    endfunction

    function automatic ecd_pkg::t_in_beat random_beat();
        ecd_pkg::t_in_beat b;
        t_stim_kind kind;
        int         pick;
        int         y;
        int         m;
        int         d;
        int         dim;
        bit         leap;
        pick = $urandom_range(0, 9);
        kind = t_stim_kind'((pick < 3) ? ANY_SECOND : (pick < 7) ? CALENDAR_DATE :
               (pick < 8) ? YEAR_EDGE : (pick < 9) ? PAST_END : RAW_WORD);
        y = $urandom_range(2099, 1970);
        m = $urandom_range(12, 1);
        leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        dim = (m == 12) ? 31 : ecd_pkg::CUM_DAYS[m] - ecd_pkg::CUM_DAYS[m - 1];
        if (m == 2 && leap) begin
            dim = 29;
        end
        case (kind)
            ANY_SECOND: b.epoch_seconds = $urandom_range(ecd_pkg::LAST_SECOND, 0);
            CALENDAR_DATE: begin
                pick = $urandom_range(0, 2);
                d = (pick == 0) ? 1 : (pick == 1) ? dim : $urandom_range(dim, 1);
                pick = $urandom_range(0, 3);
                if (pick == 0) begin
                    b.epoch_seconds = secs_at(y, m, d, 0, 0, 0);
                end else if (pick == 1) begin
                    b.epoch_seconds = secs_at(y, m, d, 23, 59, 59);
                end else begin
                    b.epoch_seconds = secs_at(y, m, d, $urandom_range(23, 0),
                                              $urandom_range(59, 0), $urandom_range(59, 0));
                end
            end
            YEAR_EDGE: begin
                // around midnight at New Year, where the year guess needs fixing
                b.epoch_seconds = secs_at(y, 1, 1, 0, 0, 0) + $urandom_range(2, 0) - 1;
                if (y == 1970 && b.epoch_seconds == 32'hFFFF_FFFF) begin
                    b.epoch_seconds = 32'd0;
                end
            end
            PAST_END: b.epoch_seconds = $urandom_range(32'hFFFF_FFFF,
                                                       ecd_pkg::LAST_SECOND + 32'd1);
            default: b.epoch_seconds = $urandom();
        endcase
        if ($urandom_range(0, 7) == 0) begin
            b.sub_second_in = 20'($urandom());
        end else begin
            b.sub_second_in = 20'($urandom_range(ecd_pkg::USEC_MAX, 0));
        end
        return b;
    endfunction

    task automatic send_beat(input logic [31:0] secs, input logic [19:0] usec);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat <= '{epoch_seconds: secs, sub_second_in: usec};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic run_random(input int idle_pct, input int stall_pct);
        ecd_pkg::t_in_beat b;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < PHASE_BEATS; n++) begin
            b = random_beat();
            send_beat(b.epoch_seconds, b.sub_second_in);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: range ends, leap days, year turnovers, microsecond saturation
        send_beat(32'd0, 20'd0);
        send_beat(ecd_pkg::LAST_SECOND, ecd_pkg::USEC_MAX);
        send_beat(ecd_pkg::LAST_SECOND + 32'd1, 20'd0);
        send_beat(32'hFFFF_FFFF, 20'hF_FFFF);
        send_beat(secs_at(1972, 2, 29, 12, 0, 0), 20'd1000000);
        send_beat(secs_at(2000, 2, 28, 23, 59, 59), 20'd1);
        send_beat(secs_at(2000, 2, 29, 23, 59, 59), 20'd500000);
        send_beat(secs_at(2000, 3, 1, 0, 0, 0), 20'd0);
        send_beat(secs_at(2001, 2, 28, 8, 30, 15), 20'h8_0000);
        send_beat(secs_at(2001, 3, 1, 0, 0, 0), 20'd999998);
        send_beat(secs_at(1970, 12, 31, 23, 59, 59), 20'd0);
        send_beat(secs_at(1972, 12, 31, 23, 59, 59), 20'd12345);
        send_beat(secs_at(1973, 1, 1, 0, 0, 0), 20'd0);
        send_beat(secs_at(1999, 12, 31, 23, 59, 59), 20'd999999);
        send_beat(secs_at(2038, 1, 19, 3, 14, 8), 20'd7);
        send_beat(32'h7FFF_FFFF, 20'h7_FFFF);
        send_beat(secs_at(2096, 2, 29, 1, 2, 3), 20'd0);
        send_beat(secs_at(2096, 12, 31, 23, 59, 59), 20'd0);
        send_beat(secs_at(2097, 1, 1, 0, 0, 0), 20'd0);
        send_beat(secs_at(2099, 1, 1, 0, 0, 0), 20'd0);
        send_beat(secs_at(2099, 12, 31, 0, 0, 0), 20'h5_5555);

        // long output hold-off while the input keeps offering beats
        hold_off_request = hold_off_request + 1;
        run_random(0, 0);
        run_random(79, 0);
        run_random(0, 79);
        run_random(12, 12);
        i_in_valid <= 1'b0;

        while (board.pending_dates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (ecd_pkg::NSTAGE + 8) @(posedge i_clk);
        if (board.errors == 0 && board.pending_dates.size() == 0) begin
            $display("PASS epoch_seconds_to_calendar_date");
        end else begin
            $display("FAIL epoch_seconds_to_calendar_date");
        end
        $finish;
    end

endmodule

### epoch_seconds_to_calendar_date.f
sv/ecd_pkg.sv
sv/ecd_front.sv
sv/ecd_date.sv
sv/ecd_tod.sv
sv/epoch_seconds_to_calendar_date.sv
sv/ecd_checker.sv
bench/tb_epoch_seconds_to_calendar_date.sv
